@@ rtl/core/psx_pkg.sv @@
// ----------------------------------------------------------------------------
// psx_pkg
// Shared types and constants of the polyline stroke expander.
// ----------------------------------------------------------------------------
package psx_pkg;

   // Coordinate format, fixed by the port structures.
   localparam int COORD_BITS  = 32;
   localparam int FRAC_BITS   = 20;
   localparam int WIDTH_BITS  = 31;
   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(64'd1 << FRAC_BITS);

   // Internal arithmetic widths.
   localparam int MAG_BITS    = COORD_BITS + 1;
   localparam int NORM_BITS   = (MAG_BITS > 31) ? MAG_BITS : 31;
   localparam int UNIT_BITS   = 30;
   localparam int ROOT_BITS   = 31;
   localparam int RAD_BITS    = 62;
   localparam int NUM_BITS    = 61;
   localparam int PROD_BITS   = WIDTH_BITS + ROOT_BITS;
   localparam int OFFSET_BITS = 33;
   localparam int VSUM_BITS   = ((COORD_BITS > OFFSET_BITS) ? COORD_BITS : OFFSET_BITS) + 1;
   localparam int STEP_BITS   = 5;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic                         first_point;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] vert_x;
      logic signed [COORD_BITS-1:0] vert_y;
      logic                         minus_side;
      logic                         at_end;
      logic                         degenerate;
      logic                         last;
   } rsp_type;

   // One segment as handed from the front to the back.
   typedef struct packed {
      logic signed [COORD_BITS-1:0] x0;
      logic signed [COORD_BITS-1:0] y0;
      logic signed [COORD_BITS-1:0] x1;
      logic signed [COORD_BITS-1:0] y1;
      logic                         degen;
   } seg_type;

endpackage

@@ rtl/core/psx_front.sv @@
// ----------------------------------------------------------------------------
// psx_front
// Accepts points, keeps the previous point and classifies each segment.
// ----------------------------------------------------------------------------
module psx_front
   import psx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   input  logic    queue_full,
   output logic    req_full,
   output logic    seg_push,
   output seg_type seg_data
);

   logic signed [COORD_BITS-1:0] prev_x_ff, prev_x_in;
   logic signed [COORD_BITS-1:0] prev_y_ff, prev_y_in;
   logic                         have_prev_ff, have_prev_in;
   logic                         accept;
   logic                         start;

   // A point is taken only when the queue has room for its segment.
   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;
   assign start    = req_data.first_point || !have_prev_ff;

   // A segment goes to the back unless this point opens a polyline.
   always_comb begin
      seg_push       = accept && !start;
      seg_data.x0    = prev_x_ff;
      seg_data.y0    = prev_y_ff;
      seg_data.x1    = req_data.point_x;
      seg_data.y1    = req_data.point_y;
      seg_data.degen = (req_data.point_x == prev_x_ff) && (req_data.point_y == prev_y_ff);
   end

   // Previous point update.
   always_comb begin
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      have_prev_in = have_prev_ff;
      if (accept) begin
         prev_x_in    = req_data.point_x;
         prev_y_in    = req_data.point_y;
         have_prev_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         have_prev_ff <= have_prev_in;
      end
   end

endmodule

@@ rtl/core/psx_fifo.sv @@
// ----------------------------------------------------------------------------
// psx_fifo
// Short segment queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module psx_fifo
   import psx_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  seg_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output seg_type pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   seg_type               store_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/psx_back.sv @@
// ----------------------------------------------------------------------------
// psx_back
// Works out the scaled unit normal of one segment with an iterative square
// root and two dividers, then presents the four vertices one at a time.
// ----------------------------------------------------------------------------
module psx_back
   import psx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [WIDTH_BITS-1:0] offset_width,
   input  logic                  seg_empty,
   input  seg_type               seg_data,
   output logic                  seg_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_NORM   = 4'd1;
   localparam logic [3:0] ST_SQUARE = 4'd2;
   localparam logic [3:0] ST_SUM    = 4'd3;
   localparam logic [3:0] ST_ROOT   = 4'd4;
   localparam logic [3:0] ST_DSETUP = 4'd5;
   localparam logic [3:0] ST_DIVIDE = 4'd6;
   localparam logic [3:0] ST_SCALE  = 4'd7;
   localparam logic [3:0] ST_ROUND  = 4'd8;
   localparam logic [3:0] ST_EMIT   = 4'd9;

   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(ROOT_BITS - 1);

   logic [3:0]                   state_ff;
   logic [STEP_BITS-1:0]         step_ff;
   logic [1:0]                   vert_ff;
   seg_type                      seg_ff;
   logic                         dx_neg_ff, dx_nz_ff, dy_neg_ff, dy_nz_ff;
   logic [NORM_BITS-1:0]         a_ff, b_ff;
   logic [2*UNIT_BITS-1:0]       sq_a_ff, sq_b_ff;
   logic [RAD_BITS-1:0]          rad_ff;
   logic [ROOT_BITS+1:0]         rem_ff;
   logic [ROOT_BITS-1:0]         root_ff;
   logic [ROOT_BITS-1:0]         num_a_ff, num_b_ff;
   logic [ROOT_BITS:0]           rem_a_ff, rem_b_ff;
   logic [ROOT_BITS-1:0]         qa_ff, qb_ff;
   logic [PROD_BITS-1:0]         pw_x_ff, pw_y_ff;
   logic signed [OFFSET_BITS-1:0] px_ff, py_ff;

   logic signed [MAG_BITS-1:0]   dx, dy;
   logic [MAG_BITS-1:0]          dx_mag, dy_mag;
   logic [NORM_BITS-1:0]         m;
   logic [ROOT_BITS+3:0]         rem_sh, trial;
   logic [NUM_BITS-1:0]          num_a, num_b;
   logic [ROOT_BITS:0]           ra_sh, rb_sh, len_ext;
   logic [PROD_BITS:0]           rx_sum, ry_sum;
   logic [OFFSET_BITS-1:0]       ox, oy;

   // Differences and magnitudes of the segment at the head of the queue.
   assign dx     = MAG_BITS'(seg_data.x1) - MAG_BITS'(seg_data.x0);
   assign dy     = MAG_BITS'(seg_data.y1) - MAG_BITS'(seg_data.y0);
   assign dx_mag = dx[MAG_BITS-1] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
   assign dy_mag = dy[MAG_BITS-1] ? MAG_BITS'(-dy) : MAG_BITS'(dy);
   assign m      = (a_ff > b_ff) ? a_ff : b_ff;
   assign seg_pop = (state_ff == ST_IDLE) && !seg_empty;

   // Square-root digit step and divider steps.
   assign rem_sh  = {rem_ff, rad_ff[RAD_BITS-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign num_a   = {1'b0, a_ff[UNIT_BITS-1:0], UNIT_BITS'(0)} + NUM_BITS'(root_ff[ROOT_BITS-1:1]);
   assign num_b   = {1'b0, b_ff[UNIT_BITS-1:0], UNIT_BITS'(0)} + NUM_BITS'(root_ff[ROOT_BITS-1:1]);
   assign len_ext = {1'b0, root_ff};
   assign ra_sh   = {rem_a_ff[ROOT_BITS-1:0], num_a_ff[ROOT_BITS-1]};
   assign rb_sh   = {rem_b_ff[ROOT_BITS-1:0], num_b_ff[ROOT_BITS-1]};

   // Rounding of the scaled offsets.
   assign rx_sum = {1'b0, pw_x_ff} + (PROD_BITS + 1)'(64'd1 << (UNIT_BITS - 1));
   assign ry_sum = {1'b0, pw_y_ff} + (PROD_BITS + 1)'(64'd1 << (UNIT_BITS - 1));
   assign ox     = rx_sum[PROD_BITS -: OFFSET_BITS];
   assign oy     = ry_sum[PROD_BITS -: OFFSET_BITS];

   // Sequencer and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         vert_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (!seg_empty) begin
                  state_ff <= seg_data.degen ? ST_EMIT : ST_NORM;
                  vert_ff  <= '0;
               end
            end
            ST_NORM: begin
               if (!(m[NORM_BITS-1:UNIT_BITS] == '0) || (m[NORM_BITS-1:UNIT_BITS-1] == '0)) begin
                  state_ff <= ST_NORM;
               end else begin
                  state_ff <= ST_SQUARE;
               end
            end
            ST_SQUARE: state_ff <= ST_SUM;
            ST_SUM: begin
               state_ff <= ST_ROOT;
               step_ff  <= '0;
            end
            ST_ROOT: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  state_ff <= ST_DSETUP;
               end
            end
            ST_DSETUP: begin
               state_ff <= ST_DIVIDE;
               step_ff  <= '0;
            end
            ST_DIVIDE: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: state_ff <= ST_ROUND;
            ST_ROUND: begin
               state_ff <= ST_EMIT;
               vert_ff  <= '0;
            end
            ST_EMIT: begin
               if (rsp_pop) begin
                  vert_ff <= vert_ff + 1'b1;
                  if (vert_ff == 2'd3) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            seg_ff    <= seg_data;
            a_ff      <= NORM_BITS'(dx_mag);
            b_ff      <= NORM_BITS'(dy_mag);
            dx_neg_ff <= dx[MAG_BITS-1];
            dx_nz_ff  <= (dx != '0);
            dy_neg_ff <= dy[MAG_BITS-1];
            dy_nz_ff  <= (dy != '0);
            px_ff     <= '0;
            py_ff     <= '0;
         end
         ST_NORM: begin
            if (!(m[NORM_BITS-1:UNIT_BITS] == '0)) begin
               a_ff <= a_ff >> 1;
               b_ff <= b_ff >> 1;
            end else if (m[NORM_BITS-1:UNIT_BITS-1] == '0) begin
               a_ff <= a_ff << 1;
               b_ff <= b_ff << 1;
            end
         end
         ST_SQUARE: begin
            sq_a_ff <= a_ff[UNIT_BITS-1:0] * a_ff[UNIT_BITS-1:0];
            sq_b_ff <= b_ff[UNIT_BITS-1:0] * b_ff[UNIT_BITS-1:0];
         end
         ST_SUM: begin
            rad_ff  <= RAD_BITS'(sq_a_ff) + RAD_BITS'(sq_b_ff);
            rem_ff  <= '0;
            root_ff <= '0;
         end
         ST_ROOT: begin
            rad_ff <= rad_ff << 2;
            if (rem_sh >= trial) begin
               rem_ff  <= (ROOT_BITS + 2)'(rem_sh - trial);
               root_ff <= {root_ff[ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_ff  <= (ROOT_BITS + 2)'(rem_sh);
               root_ff <= {root_ff[ROOT_BITS-2:0], 1'b0};
            end
         end
         ST_DSETUP: begin
            num_a_ff <= num_a[ROOT_BITS-1:0];
            num_b_ff <= num_b[ROOT_BITS-1:0];
            rem_a_ff <= (ROOT_BITS + 1)'(num_a[NUM_BITS-1:ROOT_BITS]);
            rem_b_ff <= (ROOT_BITS + 1)'(num_b[NUM_BITS-1:ROOT_BITS]);
         end
         ST_DIVIDE: begin
            num_a_ff <= num_a_ff << 1;
            num_b_ff <= num_b_ff << 1;
            if (ra_sh >= len_ext) begin
               rem_a_ff <= ra_sh - len_ext;
               qa_ff    <= {qa_ff[ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_a_ff <= ra_sh;
               qa_ff    <= {qa_ff[ROOT_BITS-2:0], 1'b0};
            end
            if (rb_sh >= len_ext) begin
               rem_b_ff <= rb_sh - len_ext;
               qb_ff    <= {qb_ff[ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_b_ff <= rb_sh;
               qb_ff    <= {qb_ff[ROOT_BITS-2:0], 1'b0};
            end
         end
         ST_SCALE: begin
            pw_x_ff <= offset_width * qb_ff;
            pw_y_ff <= offset_width * qa_ff;
         end
         ST_ROUND: begin
            px_ff <= !dy_nz_ff ? '0 : (dy_neg_ff ? -$signed(ox) : $signed(ox));
            py_ff <= !dx_nz_ff ? '0 : (dx_neg_ff ? $signed(oy) : -$signed(oy));
         end
         default: begin
         end
      endcase
   end

   // Vertex formation and saturation.
   function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [VSUM_BITS-1:0] v);
      logic signed [VSUM_BITS-1:0] hi;
      logic signed [VSUM_BITS-1:0] lo;
      hi = VSUM_BITS'({1'b0, {(COORD_BITS-1){1'b1}}});
      lo = -hi - 1;
      if (v > hi) begin
         sat = hi[COORD_BITS-1:0];
      end else if (v < lo) begin
         sat = lo[COORD_BITS-1:0];
      end else begin
         sat = v[COORD_BITS-1:0];
      end
   endfunction

   logic signed [VSUM_BITS-1:0] base_x, base_y, off_x, off_y;

   always_comb begin
      base_x = VSUM_BITS'(vert_ff[1] ? seg_ff.x1 : seg_ff.x0);
      base_y = VSUM_BITS'(vert_ff[1] ? seg_ff.y1 : seg_ff.y0);
      off_x  = VSUM_BITS'(px_ff);
      off_y  = VSUM_BITS'(py_ff);
      rsp_data.vert_x     = sat(vert_ff[0] ? base_x - off_x : base_x + off_x);
      rsp_data.vert_y     = sat(vert_ff[0] ? base_y - off_y : base_y + off_y);
      rsp_data.minus_side = vert_ff[0];
      rsp_data.at_end     = vert_ff[1];
      rsp_data.degenerate = seg_ff.degen;
      rsp_data.last       = (vert_ff == 2'd3);
   end

   assign rsp_empty = (state_ff != ST_EMIT);

endmodule

@@ rtl/core/polyline_stroke_expander_core.sv @@
// ----------------------------------------------------------------------------
// polyline_stroke_expander_core
// Expands polyline segments into the four corners of a thick-line quad.
//
//   Channel  Direction  Handshake           Payload
//   req_     in         req_push/req_full   req_type (point, first flag)
//   rsp_     out        rsp_pop/rsp_empty   rsp_type (vertex and flags)
//   csr_     in         csr_valid/csr_ready offset width, 31 bits
//
// A segment leaves the queue, is normalised by shifts, then passes 31 root
// steps, 31 divider steps for both components, five setup steps and four
// vertices at one per pop; a zero-length one goes straight to its vertices.
// The queue lets the front take further points while the back works.
// Reset is synchronous and clears the previous point, queue and sequencer.
// A stalled result simply holds until it is popped.
// ----------------------------------------------------------------------------
module polyline_stroke_expander_core
   import psx_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [WIDTH_BITS-1:0] csr_data
);

   logic [WIDTH_BITS-1:0] width_ff;
   logic                  q_full, q_empty, seg_push, seg_pop;
   seg_type               seg_in, seg_out;

   // Offset width register; a transfer is always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         width_ff <= csr_data;
      end
   end

   psx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .queue_full (q_full),
      .req_full   (req_full),
      .seg_push   (seg_push),
      .seg_data   (seg_in)
   );

   psx_fifo #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (seg_push),
      .push_data (seg_in),
      .full      (q_full),
      .pop       (seg_pop),
      .empty     (q_empty),
      .pop_data  (seg_out)
   );

   psx_back u_back (
      .clock        (clock),
      .reset        (reset),
      .offset_width (width_ff),
      .seg_empty    (q_empty),
      .seg_data     (seg_out),
      .seg_pop      (seg_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data)
   );

endmodule

@@ rtl/core/psx_checker.sv @@
// ----------------------------------------------------------------------------
// psx_checker
// Port-level checks of the stroke expander's result channel.
// ----------------------------------------------------------------------------
module psx_checker
   import psx_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // Nothing is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result offered straight after reset");

   // A waiting result holds until it is transferred.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed");

   // The final vertex is the end vertex on the minus side.
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.last) |-> (rsp_data.minus_side && rsp_data.at_end))
      else $error("last vertex at the wrong corner");

   // After a transfer of a non-final vertex the next vertex follows at once.
   a_quad_run: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last) |=> !rsp_empty)
      else $error("quad interrupted");

endmodule

bind polyline_stroke_expander_core psx_checker u_psx_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

@@ tb/sv/tb_polyline_stroke_expander_core.sv @@
// ----------------------------------------------------------------------------
// tb_polyline_stroke_expander_core
// Self-checking bench for the thick-line quad expander. Directed points and
// random polylines are pushed under random gaps and back-pressure. A
// predictor works out the four vertices of each segment, which are checked
// field by field in order. Several offset widths are used, the extremes
// among them.
// ----------------------------------------------------------------------------
module tb_polyline_stroke_expander_core
   import psx_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SETTLE_WAIT  = 150;
   localparam int ITEMS_RANDOM = 430;

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   req_type               req_data;
   logic                  rsp_empty;
   logic                  rsp_pop;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [WIDTH_BITS-1:0] csr_data;

   // Stimulus and expected vertices.
   req_type point_q[$];
   rsp_type vertex_q[$];

   // Predictor state.
   longint            last_x, last_y;
   bit                have_last;
   logic [WIDTH_BITS-1:0] width_reg;

   int  cycle_count;
   int  points_taken;
   int  errors;
   bit  req_taken, rsp_taken;
   int  send_gap, recv_gap;
   bit  hold_rsp;
   bit  no_idle;

   // Generator state for the random polylines.
   longint gen_x, gen_y;

   polyline_stroke_expander_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   // Integer square root, floor.
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned bit_v;
      root = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= root + bit_v) begin
            n -= root + bit_v;
            root = (root >> 1) + bit_v;
         end else begin
            root >>= 1;
         end
         bit_v >>= 2;
      end
      return root;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[COORD_BITS-1:0];
   endfunction

   function automatic rsp_type make_vertex(longint x, longint y, bit minus, bit at_end,
                                           bit degen, bit is_last);
      rsp_type v;
      v.vert_x     = clamp_coord(x);
      v.vert_y     = clamp_coord(y);
      v.minus_side = minus;
      v.at_end     = at_end;
      v.degenerate = degen;
      v.last       = is_last;
      return v;
   endfunction

   // Works out the quad corners for one accepted point and queues them.
   function automatic void expand_point(req_type p);
      longint x1, y1, x0, y0, dx, dy, px, py;
      longint unsigned a, b, m, len, ua, ub, ox, oy;
      bit degen;
      bit start;
      x1 = longint'(p.point_x);
      y1 = longint'(p.point_y);
      x0 = last_x;
      y0 = last_y;
      start = p.first_point || !have_last;
      last_x = x1;
      last_y = y1;
      have_last = 1'b1;
      if (start) return;
      dx = x1 - x0;
      dy = y1 - y0;
      px = 0;
      py = 0;
      degen = (dx == 0 && dy == 0);
      if (!degen) begin
         a = (dx < 0) ? -dx : dx;
         b = (dy < 0) ? -dy : dy;
         m = (a > b) ? a : b;
         while (m >= (64'd1 << 30)) begin
            m >>= 1; a >>= 1; b >>= 1;
         end
         while (m < (64'd1 << 29)) begin
            m <<= 1; a <<= 1; b <<= 1;
         end
         len = int_sqrt(a * a + b * b);
         ua = ((a << 30) + (len >> 1)) / len;
         ub = ((b << 30) + (len >> 1)) / len;
         ox = (64'(width_reg) * ub + (64'd1 << 29)) >> 30;
         oy = (64'(width_reg) * ua + (64'd1 << 29)) >> 30;
         px = (dy < 0) ? -longint'(ox) : ((dy > 0) ? longint'(ox) : 0);
         py = (dx > 0) ? -longint'(oy) : ((dx < 0) ? longint'(oy) : 0);
      end
      vertex_q.insert(vertex_q.size(),
                      make_vertex(x0 + px, y0 + py, 1'b0, 1'b0, degen, 1'b0));
      vertex_q.insert(vertex_q.size(),
                      make_vertex(x0 - px, y0 - py, 1'b1, 1'b0, degen, 1'b0));
      vertex_q.insert(vertex_q.size(),
                      make_vertex(x1 + px, y1 + py, 1'b0, 1'b1, degen, 1'b0));
      vertex_q.insert(vertex_q.size(),
                      make_vertex(x1 - px, y1 - py, 1'b1, 1'b1, degen, 1'b1));
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void add_point(longint x, longint y, bit first);
      req_type p;
      p.point_x     = x[COORD_BITS-1:0];
      p.point_y     = y[COORD_BITS-1:0];
      p.first_point = first;
      point_q.insert(point_q.size(), p);
      gen_x = longint'(p.point_x);
      gen_y = longint'(p.point_y);
   endfunction

   // Next point of a random polyline, mostly relative to the one before.
   function automatic void add_random_point(bit first);
      int mode;
      longint x, y;
      mode = $urandom_range(0, 9);
      case (mode) inside
         [0:1]: begin
            x = longint'($signed(32'($urandom())));
            y = longint'($signed(32'($urandom())));
         end
         2: begin
            x = gen_x;
            y = gen_y;
         end
         3: begin
            x = gen_x + $signed(32'($urandom_range(0, 2000000))) - 1000000;
            y = gen_y;
         end
         4: begin
            x = gen_x;
            y = gen_y + $signed(32'($urandom_range(0, 2000000))) - 1000000;
         end
         5: begin
            x = $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
            y = $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
         end
         6: begin
            x = gen_x + $signed(32'($urandom_range(0, 16))) - 8;
            y = gen_y + $signed(32'($urandom_range(0, 16))) - 8;
         end
         default: begin
            x = gen_x + $signed(32'($urandom_range(0, 64'd67108864))) - 33554432;
            y = gen_y + $signed(32'($urandom_range(0, 64'd67108864))) - 33554432;
         end
      endcase
      if (x > 64'sd2147483647) x = 64'sd2147483647;
      if (x < -64'sd2147483648) x = -64'sd2147483648;
      if (y > 64'sd2147483647) y = 64'sd2147483647;
      if (y < -64'sd2147483648) y = -64'sd2147483648;
      add_point(x, y, first);
   endfunction

   // Random polylines, with a little noise of stray first-point flags.
   function automatic void add_polylines(int count);
      int n, run;
      n = 0;
      while (n < count) begin
         run = $urandom_range(2, 12);
         add_random_point(1'b1);
         n++;
         for (int i = 1; i < run && n < count; i++) begin
            add_random_point($urandom_range(0, 19) == 0);
            n++;
         end
      end
   endfunction

   // Driver: inputs change on the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_push <= 1'b0;
         end else if (point_q.size() != 0) begin
            req_data <= point_q.pop_front();
            req_push <= 1'b1;
            send_gap = pick_gap();
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Receiver: pop with random gaps, or hold off completely.
   always @(negedge clock) begin
      if (rsp_taken) recv_gap = pick_gap();
      if (reset || hold_rsp) begin
         rsp_pop <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Monitor: samples every transfer at the rising edge.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_polyline_stroke_expander_core NOT OK");
         $finish;
      end
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) width_reg = csr_data;
         if (req_push && !req_full) begin
            req_taken = 1'b1;
            points_taken++;
            expand_point(req_data);
         end
         if (rsp_pop && !rsp_empty) begin
            rsp_type want;
            rsp_taken = 1'b1;
            if (vertex_q.size() == 0) begin
               $error("vertex transfer with none expected");
               errors++;
            end else begin
               want = vertex_q.pop_front();
               if (rsp_data.vert_x !== want.vert_x) begin
                  $error("vert_x expected %0d got %0d", want.vert_x, rsp_data.vert_x);
                  errors++;
               end
               if (rsp_data.vert_y !== want.vert_y) begin
                  $error("vert_y expected %0d got %0d", want.vert_y, rsp_data.vert_y);
                  errors++;
               end
               if (rsp_data.minus_side !== want.minus_side) begin
                  $error("minus_side expected %0b got %0b", want.minus_side,
                         rsp_data.minus_side);
                  errors++;
               end
               if (rsp_data.at_end !== want.at_end) begin
                  $error("at_end expected %0b got %0b", want.at_end, rsp_data.at_end);
                  errors++;
               end
               if (rsp_data.degenerate !== want.degenerate) begin
                  $error("degenerate expected %0b got %0b", want.degenerate,
                         rsp_data.degenerate);
                  errors++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last expected %0b got %0b", want.last, rsp_data.last);
                  errors++;
               end
            end
         end
      end
   end

   // Long receiver hold-off while the sender keeps pushing, so the input stalls.
   initial begin
      hold_rsp = 1'b0;
      wait (points_taken >= 180);
      hold_rsp = 1'b1;
      repeat (1200) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // Waits until every queued point is in and every vertex is out, then lets
   // the back end settle, since first points leave nothing to wait for.
   task automatic wait_idle();
      while (point_q.size() != 0 || req_push || vertex_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_width(logic [WIDTH_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Directed corners: no previous point, axis segments, zero length,
   // full-range jumps and saturation at the coordinate limits.
   task automatic add_directed();
      add_point(10, 20, 1'b0);
      add_point(64'sd1 << 20, 20, 1'b0);
      add_point(64'sd1 << 20, 20, 1'b0);
      add_point(64'sd1 << 20, 64'sd5 << 20, 1'b0);
      add_point(-64'sd2147483648, 64'sd2147483647, 1'b0);
      add_point(64'sd2147483647, -64'sd2147483648, 1'b0);
      add_point(0, 0, 1'b1);
      add_point(64'sd3 << 20, -(64'sd4 << 20), 1'b0);
      add_point(-7, -7, 1'b0);
      add_point(-7, -6, 1'b0);
      add_point(-8, -6, 1'b0);
      add_point(64'sd2147483647, 64'sd2147483647, 1'b1);
      add_point(64'sd2147483646, 64'sd2147483647, 1'b0);
      add_point(64'sd2147483646, 64'sd2147483640, 1'b0);
      add_point(-64'sd2147483648, -64'sd2147483648, 1'b1);
      add_point(-64'sd2147483647, -64'sd2147483647, 1'b0);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      last_x = 0;
      last_y = 0;
      have_last = 1'b0;
      width_reg = WIDTH_RESET;
      cycle_count = 0;
      points_taken = 0;
      errors = 0;
      send_gap = 0;
      recv_gap = 0;
      no_idle = 1'b0;
      gen_x = 0;
      gen_y = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset width first, then the widest and zero widths on the same points.
      add_directed();
      wait_idle();
      write_width({WIDTH_BITS{1'b1}});
      add_directed();
      wait_idle();
      write_width('0);
      add_directed();
      wait_idle();

      // Random polylines under several widths, one phase with no idling.
      write_width(WIDTH_BITS'($urandom_range(1, 64'd16777216)));
      add_polylines(ITEMS_RANDOM / 4);
      wait_idle();
      write_width(WIDTH_BITS'($urandom()));
      add_polylines(ITEMS_RANDOM / 4);
      // Sender pauses mid-phase until every vertex is out.
      wait_idle();
      add_polylines(ITEMS_RANDOM / 4);
      wait_idle();
      write_width(WIDTH_RESET);
      no_idle = 1'b1;
      add_polylines(ITEMS_RANDOM / 4);
      wait_idle();
      no_idle = 1'b0;

      if (errors == 0) begin
         $display("tb_polyline_stroke_expander_core OK");
      end else begin
         $display("tb_polyline_stroke_expander_core NOT OK");
      end
      $finish;
   end

endmodule
